// ===== design/byte_stack_with_dup_and_rotate_macros.svh =====
// Assertion macros for the byte stack block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BYTE_STACK_WITH_DUP_AND_ROTATE_MACROS_SVH
`define BYTE_STACK_WITH_DUP_AND_ROTATE_MACROS_SVH
`ifndef SYNTHESIS
`define BSDR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define BSDR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSDR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BSDR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/bsdr_pkg.sv =====
// Shared types and codes of the byte stack block.
// No dependencies; imported by the sequencer, the memory and the top level.
package bsdr_pkg;

    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;

    typedef logic [2:0] t_kind;
    localparam t_kind K_PUSH  = 3'd0;
    localparam t_kind K_POP   = 3'd1;
    localparam t_kind K_PEEK  = 3'd2;
    localparam t_kind K_DUP   = 3'd3;
    localparam t_kind K_ROTUP = 3'd4;
    localparam t_kind K_ROTDN = 3'd5;
    localparam t_kind K_DUMP  = 3'd6;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_FULL    = 3'd1;
    localparam t_status ST_EMPTY   = 3'd2;
    localparam t_status ST_ROT     = 3'd3;
    localparam t_status ST_INVALID = 3'd4;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  push_byte;
        logic [CNT_W-1:0]   rotate_count;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  out_byte;
        logic               has_byte;
        logic               last;
    } t_result;

endpackage

// ===== design/byte_stack_with_dup_and_rotate.sv =====
// Top level of the byte stack: APB capacity register, output register, sequencer and storage.
// Depends on bsdr_pkg, bsdr_mem and bsdr_seq.
//
// Use: commands enter on the s channel (tuser = kind, tdata = push byte and rotate count)
// and results leave on the m channel, one per command, or one per entry for a dump of a
// non-empty stack, with tlast set on the final result of each command. The capacity register
// sits at byte address 0 of the APB port and limits how many entries the stack may hold.
// Sequencing: a command is taken only while the sequencer is idle. For push, pop, peek,
// duplicate, rotates of fewer than two entries, refused rotates and invalid kinds, the result
// appears on the m channel in the cycle after the command is executed. A rotate over n
// entries moves one entry per cycle, as the entry memory has one read and one write port.
// A dump reads the memory once per entry, each entry leaving as its own result.
// A result waiting in the output register does not block the next command from being
// taken; the sequencer holds its next result until the register is free, so a stalled
// receiver stalls the block without losing or repeating results.
// Reset empties the stack and sets capacity to 64; the entry memory is not cleared.
module byte_stack_with_dup_and_rotate import bsdr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // Command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] push_byte, [14:8] rotate_count, [15] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] kind
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [2:0] status, [10:3] out_byte, [15:11] zero
    output logic        o_m_tuser,   // [0] has_byte
    output logic        o_m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic REG_CAPACITY = 1'b0;

    logic [CNT_W-1:0]  r_capacity;
    logic              r_out_valid;
    t_result           r_out;

    t_item             item;
    logic              slot_free;
    logic              res_valid;
    t_result           res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_CAPACITY) ? {25'b0, r_capacity} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 7'd64;
        end else if (i_psel && i_penable && i_pwrite && i_paddr[2] == REG_CAPACITY) begin
            r_capacity <= i_pwdata[CNT_W-1:0];
        end
    end

    assign item.kind         = i_s_tuser;
    assign item.push_byte    = i_s_tdata[7:0];
    assign item.rotate_count = i_s_tdata[14:8];

    // The sequencer may load a new result when the register is empty or being drained.
    assign slot_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.out_byte, r_out.status};
    assign o_m_tuser  = r_out.has_byte;
    assign o_m_tlast  = r_out.last;

    bsdr_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .LW    (LW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_in_valid  (i_s_tvalid),
        .i_item      (item),
        .o_in_ready  (o_s_tready),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    bsdr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== design/bsdr_mem.sv =====
// Stack entry storage: one write port and one read port with registered read data.
// Depends on bsdr_pkg for the byte width.
module bsdr_mem import bsdr_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bsdr_seq.sv =====
// Sequencer of the byte stack: fill level, operation decode, rotate moves and dump.
// Depends on bsdr_pkg and the assertion macro header; drives bsdr_mem through its ports.
`include "byte_stack_with_dup_and_rotate_macros.svh"
module bsdr_seq import bsdr_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_capacity,
    input  logic              i_in_valid,
    input  t_item             i_item,
    output logic              o_in_ready,
    input  logic              i_slot_free,
    output logic              o_res_valid,
    output t_result           o_res,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [BYTE_W-1:0] o_mem_wdata,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [BYTE_W-1:0] i_mem_rdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_ROT  = 6'b000100,
        S_FIN  = 6'b001000,
        S_DRD  = 6'b010000,
        S_DOUT = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [LW-1:0]     r_fill, n_fill;
    t_item             r_item, n_item;
    logic [BYTE_W-1:0] r_tmp, n_tmp;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic [AW-1:0]     r_end, n_end;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic              r_pend, n_pend;

    logic [CNT_W-1:0]  fill7;
    logic [CNT_W-1:0]  cap_eff;
    logic              full;
    logic              empty;
    logic [LW-1:0]     fill_m1;
    logic [AW-1:0]     top_addr;
    logic [CNT_W-1:0]  fill_m2;
    logic [CNT_W-1:0]  in_base;
    logic [CNT_W-1:0]  r_base;
    logic [CNT_W-1:0]  r_base_p1;
    logic              rot_up;

    always_comb begin
        fill7 = CNT_W'(r_fill);
        if (i_capacity == '0) begin
            cap_eff = CNT_W'(1);
        end else if (i_capacity > CNT_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = i_capacity;
        end
    end

    assign full      = (fill7 >= cap_eff);
    assign empty     = (r_fill == '0);
    assign fill_m1   = r_fill - LW'(1);
    assign top_addr  = fill_m1[AW-1:0];
    assign fill_m2   = fill7 - CNT_W'(2);
    assign in_base   = fill7 - i_item.rotate_count;
    assign r_base    = fill7 - r_item.rotate_count;
    assign r_base_p1 = r_base + CNT_W'(1);
    assign rot_up    = (r_item.kind == K_ROTUP);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_item      = r_item;
        n_tmp       = r_tmp;
        n_ptr       = r_ptr;
        n_wr_addr   = r_wr_addr;
        n_end       = r_end;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wr_addr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ptr;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_OK, out_byte: '0, has_byte: 1'b0, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_item;
                    o_mem_re = 1'b1;
                    // Rotate down needs the deepest entry of the group; all else the top.
                    o_mem_raddr = (i_item.kind == K_ROTDN) ? in_base[AW-1:0] : top_addr;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.kind) inside
                    K_PUSH: begin
                        o_res.status = full ? ST_FULL : ST_OK;
                        if (i_slot_free) begin
                            o_res_valid = 1'b1;
                            if (!full) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_fill[AW-1:0];
                                o_mem_wdata = r_item.push_byte;
                                n_fill      = r_fill + LW'(1);
                            end
                            n_state = S_IDLE;
                        end
                    end
                    K_POP, K_PEEK: begin
                        o_res.status   = empty ? ST_EMPTY : ST_OK;
                        o_res.has_byte = !empty;
                        o_res.out_byte = empty ? '0 : i_mem_rdata;
                        if (i_slot_free) begin
                            o_res_valid = 1'b1;
                            if (r_item.kind == K_POP && !empty) begin
                                n_fill = fill_m1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    K_DUP: begin
                        o_res.status = full ? ST_FULL : (empty ? ST_EMPTY : ST_OK);
                        if (i_slot_free) begin
                            o_res_valid = 1'b1;
                            if (!full && !empty) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_fill[AW-1:0];
                                o_mem_wdata = i_mem_rdata;
                                n_fill      = r_fill + LW'(1);
                            end
                            n_state = S_IDLE;
                        end
                    end
                    K_ROTUP, K_ROTDN: begin
                        if (r_item.rotate_count > fill7) begin
                            o_res.status = ST_ROT;
                            if (i_slot_free) begin
                                o_res_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else if (r_item.rotate_count < CNT_W'(2)) begin
                            if (i_slot_free) begin
                                o_res_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else begin
                            // The saved entry lands at the far end after n-1 moves.
                            n_tmp  = i_mem_rdata;
                            n_cnt  = LW'(r_item.rotate_count - CNT_W'(1));
                            n_pend = 1'b0;
                            if (rot_up) begin
                                n_ptr = fill_m2[AW-1:0];
                                n_end = r_base[AW-1:0];
                            end else begin
                                n_ptr = r_base_p1[AW-1:0];
                                n_end = top_addr;
                            end
                            n_state = S_ROT;
                        end
                    end
                    K_DUMP: begin
                        if (empty) begin
                            if (i_slot_free) begin
                                o_res_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else begin
                            n_ptr   = top_addr;
                            n_cnt   = r_fill;
                            n_state = S_DOUT;
                        end
                    end
                    default: begin
                        o_res.status = ST_INVALID;
                        if (i_slot_free) begin
                            o_res_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                endcase
            end
            S_ROT: begin
                // Each cycle writes the entry read in the previous cycle one place over.
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wr_addr;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_cnt != '0) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr;
                    n_wr_addr   = rot_up ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
                    n_ptr       = rot_up ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
                    n_cnt       = r_cnt - LW'(1);
                    n_pend      = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_end;
                o_mem_wdata = r_tmp;
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DRD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_ptr;
                n_state     = S_DOUT;
            end
            S_DOUT: begin
                o_res.has_byte = 1'b1;
                o_res.out_byte = i_mem_rdata;
                o_res.last     = (r_cnt == LW'(1));
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_cnt       = r_cnt - LW'(1);
                    n_ptr       = r_ptr - AW'(1);
                    n_state     = (r_cnt == LW'(1)) ? S_IDLE : S_DRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_tmp     <= n_tmp;
        r_ptr     <= n_ptr;
        r_wr_addr <= n_wr_addr;
        r_end     <= n_end;
        r_cnt     <= n_cnt;
    end

    `BSDR_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, fill7 <= CNT_W'(DEPTH), "fill over depth")
    `BSDR_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_EXEC, "no exec after accept")
    `BSDR_ASSERT_IMP(a_byte_ok, i_clk, i_rst_n, o_res_valid && o_res.has_byte, o_res.status == ST_OK, "byte with bad status")
    `BSDR_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !o_mem_we, "write while idle")

endmodule

// ===== tb/byte_stack_with_dup_and_rotate_tb.sv =====
// Self-checking testbench for the byte stack with duplicate and rotate operations.
// Drives commands, the result channel and the APB capacity register, and predicts every result.
// Depends on bsdr_pkg and the byte_stack_with_dup_and_rotate module.
`timescale 1ns / 1ps

module byte_stack_with_dup_and_rotate_tb;
    import bsdr_pkg::*;

    localparam int   DEPTH        = 64;
    localparam t_kind KIND_INVALID = 3'd7;
    localparam logic [2:0] CAP_ADDR = 3'd0;
    localparam int   SETTLE       = 8;
    localparam int   STALL_LIMIT  = 3000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_psel     = 1'b0;
    logic        i_penable  = 1'b0;
    logic        i_pwrite   = 1'b0;
    logic [2:0]  i_paddr    = '0;
    logic [31:0] i_pwdata   = '0;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [7:0] push_byte, [14:8] rotate_count, [15] zero
    logic [2:0]  i_s_tuser  = '0;   // [2:0] kind
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [2:0] status, [10:3] out_byte, [15:11] zero
    logic        o_m_tuser;         // [0] has_byte
    logic        o_m_tlast;

    byte_stack_with_dup_and_rotate #(.DEPTH(DEPTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the stack and its capacity register.
    logic [7:0] stack_bytes [DEPTH];
    int         stack_fill   = 0;
    int         capacity_reg = 64;
    t_result    awaited[$];

    int error_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    t_result got, want;

    function automatic t_result make_result(t_status st, logic [7:0] b, logic hb, logic lst);
        t_result r;
        r.status   = st;
        r.out_byte = b;
        r.has_byte = hb;
        r.last     = lst;
        return r;
    endfunction

    // Applies one command to the shadow stack and queues the results it must produce.
    task automatic stack_apply(input t_kind kind, input logic [7:0] push_byte,
                               input logic [6:0] count);
        int         lim;
        int         base;
        logic [7:0] tmp;
        lim = (capacity_reg < 1) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
        case (kind) inside
            K_PUSH: begin
                if (stack_fill >= lim) begin
                    awaited.push_back(make_result(ST_FULL, 8'h00, 1'b0, 1'b1));
                end else begin
                    stack_bytes[stack_fill] = push_byte;
                    stack_fill++;
                    awaited.push_back(make_result(ST_OK, 8'h00, 1'b0, 1'b1));
                end
            end
            K_POP, K_PEEK: begin
                if (stack_fill == 0) begin
                    awaited.push_back(make_result(ST_EMPTY, 8'h00, 1'b0, 1'b1));
                end else begin
                    tmp = stack_bytes[stack_fill - 1];
                    if (kind == K_POP) stack_fill--;
                    awaited.push_back(make_result(ST_OK, tmp, 1'b1, 1'b1));
                end
            end
            K_DUP: begin
                // Full is checked before empty.
                if (stack_fill >= lim) begin
                    awaited.push_back(make_result(ST_FULL, 8'h00, 1'b0, 1'b1));
                end else if (stack_fill == 0) begin
                    awaited.push_back(make_result(ST_EMPTY, 8'h00, 1'b0, 1'b1));
                end else begin
                    stack_bytes[stack_fill] = stack_bytes[stack_fill - 1];
                    stack_fill++;
                    awaited.push_back(make_result(ST_OK, 8'h00, 1'b0, 1'b1));
                end
            end
            K_ROTUP, K_ROTDN: begin
                if (int'(count) > stack_fill) begin
                    awaited.push_back(make_result(ST_ROT, 8'h00, 1'b0, 1'b1));
                end else begin
                    if (count >= 2) begin
                        base = stack_fill - int'(count);
                        if (kind == K_ROTUP) begin
                            tmp = stack_bytes[stack_fill - 1];
                            for (int i = stack_fill - 1; i > base; i--)
                                stack_bytes[i] = stack_bytes[i - 1];
                            stack_bytes[base] = tmp;
                        end else begin
                            tmp = stack_bytes[base];
                            for (int i = base; i + 1 < stack_fill; i++)
                                stack_bytes[i] = stack_bytes[i + 1];
                            stack_bytes[stack_fill - 1] = tmp;
                        end
                    end
                    awaited.push_back(make_result(ST_OK, 8'h00, 1'b0, 1'b1));
                end
            end
            K_DUMP: begin
                if (stack_fill == 0) begin
                    awaited.push_back(make_result(ST_OK, 8'h00, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < stack_fill; i++)
                        awaited.push_back(make_result(ST_OK, stack_bytes[stack_fill - 1 - i],
                                                      1'b1, (i + 1 == stack_fill)));
                end
            end
            default: begin
                awaited.push_back(make_result(ST_INVALID, 8'h00, 1'b0, 1'b1));
            end
        endcase
    endtask

    task automatic send_item(input t_kind kind, input logic [7:0] push_byte,
                             input logic [6:0] count);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {1'b0, count, push_byte};
        do @(posedge i_clk); while (!o_s_tready);
        stack_apply(kind, push_byte, count);
    endtask

    // Stops offering items and waits until every queued result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= write;
        i_paddr   <= CAP_ADDR;
        i_pwdata  <= wdata;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic set_capacity(input int value);
        logic [31:0] rd;
        wait_idle();
        apb_access(1'b1, value, rd);
        capacity_reg = value;
        apb_access(1'b0, 32'd0, rd);
        if (rd !== 32'(value)) begin
            $error("capacity readback: expected %0d, got %0d", value, rd);
            error_count++;
        end
    endtask

    task automatic send_random_op();
        int         r;
        t_kind      kind;
        logic [7:0] b;
        logic [6:0] cnt;
        b   = 8'($urandom_range(255));
        cnt = 7'($urandom_range(127));
        r   = int'($urandom_range(99));
        if (r < 28)      kind = K_PUSH;
        else if (r < 40) kind = K_POP;
        else if (r < 48) kind = K_PEEK;
        else if (r < 58) kind = K_DUP;
        else if (r < 70) begin kind = K_ROTUP; cnt = 7'($urandom_range(stack_fill + 1)); end
        else if (r < 82) begin kind = K_ROTDN; cnt = 7'($urandom_range(stack_fill + 1)); end
        else if (r < 89) kind = K_DUMP;
        else if (r < 93) kind = KIND_INVALID;
        else             kind = r[0] ? K_ROTUP : K_ROTDN;   // count left wild
        send_item(kind, b, cnt);
    endtask

    task automatic test_directed();
        send_item(K_POP,   8'h00, 7'd0);
        send_item(K_PEEK,  8'h00, 7'd0);
        send_item(K_DUP,   8'h00, 7'd0);
        send_item(K_DUMP,  8'h00, 7'd0);
        send_item(K_ROTUP, 8'h00, 7'd1);
        send_item(K_ROTDN, 8'h00, 7'd0);
        send_item(K_PUSH,  8'h00, 7'd0);
        send_item(K_PUSH,  8'hFF, 7'd127);
        send_item(K_PUSH,  8'h5A, 7'd0);
        send_item(K_PEEK,  8'h00, 7'd0);
        send_item(K_DUP,   8'h00, 7'd0);
        send_item(K_PUSH,  8'h81, 7'd64);
        send_item(K_ROTUP, 8'h00, 7'd4);
        send_item(K_ROTDN, 8'h00, 7'd3);
        send_item(K_ROTUP, 8'h00, 7'd1);
        send_item(K_ROTDN, 8'h00, 7'd6);
        send_item(K_ROTUP, 8'hFF, 7'd127);
        send_item(KIND_INVALID, 8'hFF, 7'd127);
        send_item(K_DUMP,  8'h00, 7'd0);
        send_item(K_ROTDN, 8'h00, 7'd5);
        send_item(K_POP,   8'h00, 7'd0);
        send_item(K_POP,   8'h00, 7'd0);
    endtask

    // Capacity below the fill level, and the out-of-range register values.
    task automatic test_capacity_limits();
        set_capacity(2);
        send_item(K_PUSH,  8'h33, 7'd0);
        send_item(K_DUP,   8'h00, 7'd0);
        send_item(K_ROTUP, 8'h00, 7'd3);
        send_item(K_DUMP,  8'h00, 7'd0);
        repeat (4) send_item(K_POP, 8'h00, 7'd0);
        set_capacity(0);
        send_item(K_PUSH,  8'hC3, 7'd0);
        send_item(K_PUSH,  8'h3C, 7'd0);
        send_item(K_DUP,   8'h00, 7'd0);
        send_item(K_PEEK,  8'h00, 7'd0);
        send_item(K_POP,   8'h00, 7'd0);
        set_capacity(1);
        send_item(K_PUSH,  8'h96, 7'd0);
        send_item(K_DUP,   8'h00, 7'd0);
        send_item(K_ROTDN, 8'h00, 7'd1);
        send_item(K_POP,   8'h00, 7'd0);
        set_capacity(127);
        repeat (3) send_item(K_PUSH, 8'($urandom_range(255)), 7'd0);
    endtask

    task automatic test_idle_phase(input int tx_pct, input int rx_pct, input int cap,
                                   input int count);
        set_capacity(cap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_random_op();
    endtask

    // The receiver holds off while items keep coming, so the block must stall its input.
    task automatic test_output_stall();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = 300;
        send_item(K_PUSH, 8'h11, 7'd0);
        send_item(K_DUMP, 8'h00, 7'd0);
        repeat (6) send_random_op();
        wait_idle();
    endtask

    task automatic test_full_depth();
        set_capacity(64);
        tx_idle_pct  = 14;
        rx_stall_pct = 14;
        while (stack_fill < DEPTH) send_item(K_PUSH, 8'($urandom_range(255)), 7'd0);
        send_item(K_PUSH,  8'hEE, 7'd0);
        send_item(K_DUP,   8'h00, 7'd0);
        send_item(K_ROTUP, 8'h00, 7'd64);
        send_item(K_ROTDN, 8'h00, 7'd64);
        send_item(K_ROTDN, 8'h00, 7'd65);
        send_item(K_DUMP,  8'h00, 7'd0);
        send_item(K_PEEK,  8'h00, 7'd0);
        send_item(K_POP,   8'h00, 7'd0);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_m_tready   <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status   = o_m_tdata[2:0];
            got.out_byte = o_m_tdata[10:3];
            got.has_byte = o_m_tuser;
            got.last     = o_m_tlast;
            if (awaited.size() == 0) begin
                $error("result with no expectation waiting: status %0d, out_byte %0h",
                       got.status, got.out_byte);
                error_count++;
            end else begin
                want = awaited.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                    error_count++;
                end
                if (got.has_byte !== want.has_byte) begin
                    $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (i_psel && i_penable))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_capacity_limits();
        test_idle_phase(0, 0, 10, 5);
        test_idle_phase(80, 0, 64, 5);
        test_idle_phase(0, 80, 3, 5);
        test_idle_phase(14, 14, $urandom_range(4, 24), 5);
        test_output_stall();
        test_full_depth();
        wait_idle();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
